// File: sv/clces_pkg.sv
// ----------------------------------------------------------------------------
// clces_pkg: shared types and constants of the character LCD sequencer
// Holds the request kinds, the job descriptor passed from the front end to
// the back end, status structs and the fixed tables of the display protocol.
// ----------------------------------------------------------------------------
package clces_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_GOTO = 2'd1,
      KIND_INIT = 2'd2,
      KIND_RAW  = 2'd3
   } kind_type;

   // Configuration register indexes.
   localparam logic CSR_BACKLIGHT = 1'b0;
   localparam logic CSR_ADDRESS   = 1'b1;

   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_SETDDRAM = 8'h80;

   // Job queue depth; the pointers wrap naturally, so it stays a power of two.
   localparam int         QUEUE_DEPTH     = 4;

   // Step counter covers the longest sequence (initialization, 25 beats).
   localparam int         STEP_W          = 5;
   localparam logic [4:0] BYTE_LAST_STEP  = 5'd3;
   localparam logic [4:0] INIT_LAST_STEP  = 5'd24;

   // One LCD transfer, or the whole power-up sequence when init is set.
   typedef struct packed {
      logic       init;
      logic       rs;
      logic [7:0] lcd_byte;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic              active;
      logic              init;
      logic [STEP_W-1:0] step;
   } back_status_type;

   // DDRAM line base address for one-based rows 1..4; other rows use line 1.
   function automatic logic [7:0] line_base(input logic [7:0] row);
      logic [7:0] base;
      unique case (row)
         8'd2:    base = 8'h40;
         8'd3:    base = 8'h14;
         8'd4:    base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

   // Nibble carried by each beat of the power-up sequence. Beat 0 is the raw
   // zero byte; then the wake-up nibbles 3, 3, 3, 2 and the setup commands
   // 0x28, 0x0C, 0x01, 0x06, two beats per nibble.
   function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
      logic [3:0] nib;
      unique case (step)
         5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: nib = 4'h3;
         5'd7, 5'd8, 5'd9, 5'd10:            nib = 4'h2;
         5'd11, 5'd12:                       nib = 4'h8;
         5'd15, 5'd16:                       nib = 4'hC;
         5'd19, 5'd20:                       nib = 4'h1;
         5'd23, 5'd24:                       nib = 4'h6;
         default:                            nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

// File: sv/clces_front.sv
// ----------------------------------------------------------------------------
// clces_front: request classifier
// Accepts requests, tracks the cursor row and turns each request into one
// job for the back end.
// ----------------------------------------------------------------------------
module clces_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [7:0]                  req_char_code,
   input  logic [7:0]                  req_column,
   input  logic [7:0]                  req_row,
   input  logic                        req_register_select,
   input  clces_pkg::queue_status_type q_status,
   output logic                        push,
   output clces_pkg::job_type          push_job
);

   logic [7:0]          cursor_ff;
   logic [7:0]          cursor_in;
   logic [7:0]          goto_row;
   logic [7:0]          goto_col;
   logic [7:0]          goto_byte;
   clces_pkg::kind_type kind;

   assign kind      = clces_pkg::kind_type'(req_kind);
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // A newline is a goto to column 1 of the row below the current one.
   always_comb begin
      if (kind == clces_pkg::KIND_GOTO) begin
         goto_row = req_row;
         goto_col = req_column;
      end else begin
         goto_row = cursor_ff + 8'd2;
         goto_col = 8'd1;
      end
      goto_byte = clces_pkg::CMD_SETDDRAM
                | (clces_pkg::line_base(goto_row) + (goto_col - 8'd1));
   end

   always_comb begin
      push_job.init     = 1'b0;
      push_job.rs       = 1'b0;
      push_job.lcd_byte = req_char_code;
      cursor_in         = cursor_ff;
      unique case (kind)
         clces_pkg::KIND_CHAR: begin
            priority if (req_char_code == clces_pkg::CHAR_FF) begin
               push_job.lcd_byte = clces_pkg::CMD_CLEAR;
               cursor_in         = 8'd0;
            end else if (req_char_code == clces_pkg::CHAR_NL) begin
               push_job.lcd_byte = goto_byte;
               cursor_in         = goto_row - 8'd1;
            end else begin
               push_job.rs = 1'b1;
            end
         end
         clces_pkg::KIND_GOTO: begin
            push_job.lcd_byte = goto_byte;
            cursor_in         = goto_row - 8'd1;
         end
         clces_pkg::KIND_INIT: begin
            push_job.init = 1'b1;
            cursor_in     = 8'd0;
         end
         clces_pkg::KIND_RAW: begin
            push_job.rs = req_register_select;
         end
         default: begin
            push_job.init = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 8'd0;
      end else if (push) begin
         cursor_ff <= cursor_in;
      end
   end

endmodule

// File: sv/clces_queue.sv
// ----------------------------------------------------------------------------
// clces_queue: job queue
// A small first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module clces_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  clces_pkg::job_type          push_job,
   input  logic                        pop,
   output clces_pkg::job_type          head,
   output clces_pkg::queue_status_type status
);

   localparam int DEPTH = clces_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   clces_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/clces_back.sv
// ----------------------------------------------------------------------------
// clces_back: expander byte sequencer
// Takes jobs from the queue and steps through their expander bytes, one
// beat per cycle while rsp_stall does not hold it, into a registered output.
// ----------------------------------------------------------------------------
module clces_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        backlight_on,
   input  logic [6:0]                  device_address,
   input  clces_pkg::queue_status_type q_status,
   input  clces_pkg::job_type          q_head,
   output logic                        pop,
   output clces_pkg::back_status_type  status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [6:0]                  rsp_bus_address,
   output logic [7:0]                  rsp_expander_byte,
   output logic                        rsp_last
);

   logic                           active_ff;
   logic                           active_in;
   clces_pkg::job_type             job_ff;
   logic [clces_pkg::STEP_W-1:0]   step_ff;
   logic [clces_pkg::STEP_W-1:0]   step_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [6:0]                     addr_ff;
   logic [7:0]                     byte_ff;
   logic [7:0]                     byte_in;
   logic                           last_ff;
   logic                           last_in;
   clces_pkg::job_type             cur_job;
   logic [clces_pkg::STEP_W-1:0]   cur_step;
   logic                           advance;
   logic                           emit;
   logic [3:0]                     nib;
   logic                           en;

   assign cur_job  = active_ff ? job_ff : q_head;
   assign cur_step = active_ff ? step_ff : '0;
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign emit     = advance && (active_ff || !q_status.empty);
   assign pop      = emit && !active_ff;

   // Byte jobs: high nibble then low nibble, each with enable high then low.
   always_comb begin
      if (cur_job.init) begin
         nib     = clces_pkg::init_nibble(cur_step);
         en      = cur_step[0];
         last_in = (cur_step == clces_pkg::INIT_LAST_STEP);
         if (cur_step == '0) begin
            byte_in = 8'h00;
         end else begin
            byte_in = {nib, backlight_on, en, 1'b0, 1'b0};
         end
      end else begin
         nib     = cur_step[1] ? cur_job.lcd_byte[3:0] : cur_job.lcd_byte[7:4];
         en      = !cur_step[0];
         last_in = (cur_step == clces_pkg::BYTE_LAST_STEP);
         byte_in = {nib, backlight_on, en, 1'b0, cur_job.rs};
      end
   end

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         active_in = !last_in;
         step_in   = cur_step + clces_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= q_head;
      end
      if (emit) begin
         addr_ff <= device_address;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign status.active     = active_ff;
   assign status.init       = job_ff.init;
   assign status.step       = step_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bus_address   = addr_ff;
   assign rsp_expander_byte = byte_ff;
   assign rsp_last          = last_ff;

endmodule

// File: sv/char_lcd_expander_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_expander_sequencer: 4-bit character LCD sequencer for an I2C
// port expander.
// Turns display requests into the expander pin bytes that drive the panel.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (req_*) is taken when req_valid is high and req_stall is
// low. Kinds are put character, goto position, initialize and raw byte.
// Each request produces a burst of response beats (rsp_*): four expander
// bytes for any one LCD byte, 25 for initialization. rsp_last marks the
// final beat of a burst, and every beat carries the configured bus address.
// When the block is empty, an accepted request passes through the job queue
// and then the output register before rsp_valid rises with its first beat.
// The back end emits one beat per cycle while rsp_stall is low; throughput
// is set by the number of beats each request expands into, not by the front
// end.
// A four-entry job queue decouples request intake from output, so requests
// keep being taken while a burst drains or the receiver stalls. When the
// receiver holds rsp_stall, the current beat holds and the sequencer waits;
// req_stall rises only once the queue is full.
// The csr_* port writes backlight_on (index 0) and device_address (index 1);
// write them only while the block is idle.
// Reset clears the queue, the output and the cursor row, and restores the
// backlight on and the address to 63.
// ----------------------------------------------------------------------------
module char_lcd_expander_sequencer (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   input  logic       req_register_select,
   // Response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_bus_address,
   output logic [7:0] rsp_expander_byte,
   output logic       rsp_last,
   // Configuration write port
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   logic                        backlight_ff;
   logic [6:0]                  devaddr_ff;
   logic                        push;
   logic                        pop;
   clces_pkg::job_type          push_job;
   clces_pkg::job_type          q_head;
   clces_pkg::queue_status_type q_status;
   clces_pkg::back_status_type  b_status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b1;
         devaddr_ff   <= 7'd63;
      end else if (csr_write) begin
         unique case (csr_index)
            clces_pkg::CSR_BACKLIGHT: backlight_ff <= csr_wdata[0];
            clces_pkg::CSR_ADDRESS:   devaddr_ff   <= csr_wdata;
            default:                  devaddr_ff   <= devaddr_ff;
         endcase
      end
   end

   // Front end: classifies each request and tracks the cursor row.
   clces_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_column          (req_column),
      .req_row             (req_row),
      .req_register_select (req_register_select),
      .q_status            (q_status),
      .push                (push),
      .push_job            (push_job)
   );

   // Job queue between the two halves.
   clces_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (q_head),
      .status   (q_status)
   );

   // Back end: steps through the expander bytes of each job.
   clces_back u_back (
      .clock             (clock),
      .reset             (reset),
      .backlight_on      (backlight_ff),
      .device_address    (devaddr_ff),
      .q_status          (q_status),
      .q_head            (q_head),
      .pop               (pop),
      .status            (b_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bus_address   (rsp_bus_address),
      .rsp_expander_byte (rsp_expander_byte),
      .rsp_last          (rsp_last)
   );

   // The queue can never report full and empty together.
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("job queue reports full and empty at once");

   // A byte job in progress never runs past its fourth beat.
   assert property (@(posedge clock) disable iff (reset)
      (b_status.active && !b_status.init) |-> (b_status.step <= clces_pkg::BYTE_LAST_STEP))
      else $error("byte job step out of range");

   // A request into an idle block passes the queue, then the output register.
   assert property (@(posedge clock) disable iff (reset)
      (push && q_status.empty && !b_status.active && !rsp_valid) |=> ##1 rsp_valid)
      else $error("first beat of a request did not appear");

   // No job is popped from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty job queue");

endmodule
